FILE: hw/rtl/lisl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisl_pkg: shared types and defaults for the LIS length unit
// Holds the default sizes and the control word that travels with each
// request along the chain of tail cells.
// ----------------------------------------------------------------------------
package lisl_pkg;

    // Default number of tail cells (the deepest length that can be tracked).
    localparam int DEF_MAX_LEN    = 1024;
    // Default width of one element.
    localparam int DEF_DATA_WIDTH = 32;

    // Control word that moves with a request from cell to cell.
    typedef struct packed {
        logic vld;     // a request occupies this slot
        logic first;   // the request starts a new sequence
        logic skip;    // extreme value: leaves the table untouched
        logic placed;  // the value has already been stored in some cell
    } tok_ctrl_t;

endpackage

FILE: hw/rtl/lisl_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisl_ifs: request and result channels of the LIS length unit
// Valid/ready channels; an item moves at a rising edge with both high.
// ----------------------------------------------------------------------------

// Element channel: one signed value and the start-of-sequence flag.
interface lisl_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         first;

    modport source (output valid, output value, output first, input ready);
    modport sink   (input valid, input value, input first, output ready);
endinterface

// Result channel: current length and the table-full flag.
interface lisl_out_if #(
    parameter int LEN_W = 11
);
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] length;
    logic             full_res;

    modport source (output valid, output length, output full_res, input ready);
    modport sink   (input valid, input length, input full_res, output ready);
endinterface

FILE: hw/rtl/lisl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisl_cell: one tail cell of the patience-sorting chain
// Holds one tail and its occupancy. A passing request that is not yet placed
// replaces the tail if the tail is not smaller, or fills the cell if it is
// empty. The request then moves on with a running count of occupied cells.
// ----------------------------------------------------------------------------
module lisl_cell
    import lisl_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int LEN_W      = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  tok_ctrl_t             ctrl_in,
    input  logic [DATA_WIDTH-1:0] key_in,
    input  logic [LEN_W-1:0]      len_in,
    output tok_ctrl_t             ctrl_out,
    output logic [DATA_WIDTH-1:0] key_out,
    output logic [LEN_W-1:0]      len_out
);

    logic [DATA_WIDTH-1:0] tail_reg, tail_next;
    logic                  occ_reg, occ_next;
    tok_ctrl_t             ctrl_reg, ctrl_next;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [LEN_W-1:0]      len_reg, len_next;

    logic occ_eff;
    logic act;
    logic hit;

    // A new sequence empties the cell before the request looks at it.
    assign occ_eff = occ_reg & ~(ctrl_in.vld & ctrl_in.first);
    assign act     = ctrl_in.vld & ~ctrl_in.skip & ~ctrl_in.placed;
    assign hit     = act & (~occ_eff | (tail_reg >= key_in));

    // Next cell state and the request handed to the neighbor.
    always_comb
    begin
        tail_next        = hit ? key_in : tail_reg;
        occ_next         = ctrl_in.vld ? (occ_eff | hit) : occ_reg;
        ctrl_next        = ctrl_in;
        ctrl_next.placed = ctrl_in.placed | hit;
        len_next         = len_in + LEN_W'(occ_next);
    end

    // Control state of the cell and of the request slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            ctrl_reg <= '0;
        end
        else if (adv)
        begin
            occ_reg  <= occ_next;
            ctrl_reg <= ctrl_next;
        end
    end

    // Tail value and request payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_reg <= tail_next;
            key_reg  <= key_in;
            len_reg  <= len_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign key_out  = key_reg;
    assign len_out  = len_reg;

`ifndef SYNTH
    // An extreme value never lands in any cell.
    a_skip_not_placed: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.vld && ctrl_reg.skip) |-> !ctrl_reg.placed)
        else $error("lisl_cell: skipped request marked as placed");

    // A hit stores exactly the key that moves on with the request.
    a_hit_stores_key: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && hit) |=> (tail_reg == key_reg && occ_reg && ctrl_reg.placed))
        else $error("lisl_cell: tail does not match the placed key");

    // Only a new sequence can empty an occupied cell.
    a_occ_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && ctrl_in.vld && !ctrl_in.first && occ_reg) |=> occ_reg)
        else $error("lisl_cell: occupied cell lost without a new sequence");
`endif

endmodule

FILE: hw/rtl/lisl_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisl_result: end of the chain and result register
// Keeps the table-full flag, turns each request leaving the last cell into
// a result and holds it until the result channel takes it.
// ----------------------------------------------------------------------------
module lisl_result
    import lisl_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN,
    parameter int LEN_W   = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tok_ctrl_t        ctrl_in,
    input  logic [LEN_W-1:0] len_in,
    input  logic             out_ready,
    output logic             adv,
    output logic             out_valid,
    output logic [LEN_W-1:0] length,
    output logic             full_res
);

    logic             ovf_reg, ovf_next;
    logic             valid_reg, valid_next;
    logic [LEN_W-1:0] length_reg;
    logic             full_reg;

    // The whole chain moves whenever the result register is free or drained.
    assign adv = ~valid_reg | out_ready;

    // A request that reached the end unplaced would have extended a full table.
    always_comb
    begin
        ovf_next   = ovf_reg;
        valid_next = valid_reg;
        if (adv)
        begin
            valid_next = ctrl_in.vld;
            if (ctrl_in.vld)
            begin
                ovf_next = (ovf_reg & ~ctrl_in.first) |
                           (~ctrl_in.skip & ~ctrl_in.placed);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (adv && ctrl_in.vld)
        begin
            length_reg <= len_in;
            full_reg   <= ovf_next;
        end
    end

    assign out_valid = valid_reg;
    assign length    = length_reg;
    assign full_res  = full_reg;

`ifndef SYNTH
    // A new sequence always starts with the full flag clear unless it overflows.
    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && ctrl_in.vld && ctrl_in.first && (ctrl_in.placed || ctrl_in.skip))
        |=> !ovf_reg)
        else $error("lisl_result: full flag survived a new sequence");

    // The reported length never exceeds the number of cells.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (length_reg <= LEN_W'(MAX_LEN)))
        else $error("lisl_result: length beyond table depth");

    // Overflow is only reported with a full table.
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && ctrl_in.vld && !ctrl_in.skip && !ctrl_in.placed)
        |-> (len_in == LEN_W'(MAX_LEN)))
        else $error("lisl_result: dropped extension with free cells");
`endif

endmodule

FILE: hw/rtl/longest_increasing_subsequence_length_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_length_unit: LIS length by patience sorting
//
//   Channel  Dir  Payload                       Moves when
//   req      in   value (signed), first          req.valid & req.ready
//   res      out  length, full_res               res.valid & res.ready
//
// One request per cycle is taken while the chain advances; its result is
// registered in the first cell at the edge that takes it and then moves from
// cell to cell through all MAX_LEN cells into the result register.
// A stalled result holds the whole chain, and req.ready drops with it.
// Reset empties every cell and clears the full flag at once; no pass over
// the cells is needed.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_length_unit
    import lisl_pkg::*;
#(
    parameter int MAX_LEN    = DEF_MAX_LEN,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int LEN_W      = $clog2(MAX_LEN + 1)
) (
    input  logic  clk,
    input  logic  rst_n,
    lisl_in_if.sink    req,
    lisl_out_if.source res
);

    tok_ctrl_t             ctrl_chain [MAX_LEN+1];
    logic [DATA_WIDTH-1:0] key_chain  [MAX_LEN+1];
    logic [LEN_W-1:0]      len_chain  [MAX_LEN+1];

    logic                  adv;
    logic [DATA_WIDTH-1:0] key_in;
    logic                  skip_in;

    // Offset-binary key so that an unsigned compare follows signed order;
    // the most negative and most positive values are ignored.
    assign key_in  = req.value ^ {1'b1, {(DATA_WIDTH-1){1'b0}}};
    assign skip_in = (key_in == '0) || (key_in == '1);

    assign req.ready = adv;

    // Entry into the first cell.
    assign ctrl_chain[0] = '{vld: req.valid, first: req.first, skip: skip_in, placed: 1'b0};
    assign key_chain[0]  = key_in;
    assign len_chain[0]  = '0;

    // Row of tail cells, one request slot per cell.
    for (genvar k = 0; k < MAX_LEN; k++)
    begin : g_cell
        lisl_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .LEN_W      (LEN_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .ctrl_in  (ctrl_chain[k]),
            .key_in   (key_chain[k]),
            .len_in   (len_chain[k]),
            .ctrl_out (ctrl_chain[k+1]),
            .key_out  (key_chain[k+1]),
            .len_out  (len_chain[k+1])
        );
    end

    // Full flag and result register.
    lisl_result #(
        .MAX_LEN (MAX_LEN),
        .LEN_W   (LEN_W)
    ) u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_in   (ctrl_chain[MAX_LEN]),
        .len_in    (len_chain[MAX_LEN]),
        .out_ready (res.ready),
        .adv       (adv),
        .out_valid (res.valid),
        .length    (res.length),
        .full_res  (res.full_res)
    );

endmodule

FILE: test/lisl_length_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lisl_length_check: result predictor and comparator for the LIS length unit
// Watches both channels. Every accepted request is run through a private
// patience-sorting table, and the length and full flag it gives are queued.
// Every accepted result is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module lisl_length_check #(
    parameter int MAX_LEN    = 1024,
    parameter int DATA_WIDTH = 32,
    parameter int LEN_W      = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  logic [DATA_WIDTH-1:0] req_value,
    input  logic                  req_first,
    input  logic                  res_valid,
    input  logic                  res_ready,
    input  logic [LEN_W-1:0]      res_length,
    input  logic                  res_full,
    output int                    fail_cnt,
    output int                    pending_cnt
);

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             full_res;
    } lis_res_t;

    localparam logic [DATA_WIDTH-1:0] SIGN_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Tails kept as offset-binary keys so an unsigned compare follows signed order.
    logic [DATA_WIDTH-1:0] tail_key [MAX_LEN];
    int                    tails_used;
    logic                  table_full;

    lis_res_t length_due_q [$];
    int       mismatches;

    initial
    begin
        tails_used  = 0;
        table_full  = 1'b0;
        mismatches  = 0;
        fail_cnt    = 0;
        pending_cnt = 0;
    end

    // Applies one request to the tail table and returns the length it leaves.
    function automatic lis_res_t place_in_tails(input logic [DATA_WIDTH-1:0] v,
                                                input logic f);
        logic [DATA_WIDTH-1:0] key;
        int                    pos;
        lis_res_t              r;
        key = v ^ SIGN_BIT;
        if (f)
        begin
            tails_used = 0;
            table_full = 1'b0;
        end
        // The most negative and most positive values leave everything as is.
        if (key != '0 && key != '1)
        begin
            pos = 0;
            while (pos < tails_used && tail_key[pos] < key)
                pos++;
            if (pos < tails_used)
                tail_key[pos] = key;
            else if (tails_used < MAX_LEN)
            begin
                tail_key[tails_used] = key;
                tails_used++;
            end
            else
                table_full = 1'b1;
        end
        r.length   = LEN_W'(tails_used);
        r.full_res = table_full;
        return r;
    endfunction

    // Compare results against the queue, then predict for the new request.
    always @(posedge clk)
    begin
        lis_res_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (length_due_q.size() == 0)
                begin
                    $display("%0t: unexpected result, got length=%0d full_res=%0b",
                             $time, res_length, res_full);
                    mismatches++;
                end
                else
                begin
                    want = length_due_q.pop_front();
                    if (res_length !== want.length || res_full !== want.full_res)
                    begin
                        if (res_length !== want.length)
                            $display("%0t: length mismatch, expected %0d, actual %0d",
                                     $time, want.length, res_length);
                        if (res_full !== want.full_res)
                            $display("%0t: full_res mismatch, expected %0b, actual %0b",
                                     $time, want.full_res, res_full);
                        mismatches++;
                    end
                end
            end
            if (req_valid && req_ready)
                length_due_q.push_back(place_in_tails(req_value, req_first));
        end
        fail_cnt    <= mismatches;
        pending_cnt <= length_due_q.size();
    end

endmodule

FILE: test/tb_longest_increasing_subsequence_length_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_increasing_subsequence_length_unit: stimulus and verdict
// Drives directed corner requests, then random sequences of many shapes,
// in bursts with gaps, while the result side stalls on its own pattern.
// The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_longest_increasing_subsequence_length_unit;
    import lisl_pkg::*;

    localparam int MAX_LEN     = DEF_MAX_LEN;
    localparam int DW          = DEF_DATA_WIDTH;
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int N_RANDOM    = 680;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};

    logic clk;
    logic rst_n;
    int   fail_cnt;
    int   pending_cnt;
    int   cycle_cnt;
    int   burst_left;
    int   stall_mode;
    int   stall_left;
    int   stall_tick;

    lisl_in_if  #(.DATA_WIDTH(DW)) req_ch ();
    lisl_out_if #(.LEN_W(LEN_W))   res_ch ();

    longest_increasing_subsequence_length_unit #(
        .MAX_LEN    (MAX_LEN),
        .DATA_WIDTH (DW)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    lisl_length_check #(
        .MAX_LEN    (MAX_LEN),
        .DATA_WIDTH (DW),
        .LEN_W      (LEN_W)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_ch.valid),
        .req_ready   (req_ch.ready),
        .req_value   (req_ch.value),
        .req_first   (req_ch.first),
        .res_valid   (res_ch.valid),
        .res_ready   (res_ch.ready),
        .res_length  (res_ch.length),
        .res_full    (res_ch.full_res),
        .fail_cnt    (fail_cnt),
        .pending_cnt (pending_cnt)
    );

    // Clock, 8 ns period.
    initial
        clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit.
    initial
        cycle_cnt = 0;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result-side stalls: free flow, coin flips, mostly stalled, or a fixed rhythm.
    initial
    begin
        stall_mode = 0;
        stall_left = 0;
        stall_tick = 0;
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= $urandom_range(0, 1);
            2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
            default: res_ch.ready <= (stall_tick % 5 != 0);
        endcase
    end

    // Sends one request; a new burst starts with a random gap.
    task automatic send_elem(input logic [DW-1:0] v, input logic f);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.value <= v;
        req_ch.first <= f;
        do
            @(posedge clk);
        while (!req_ch.ready);
        burst_left--;
    endtask

    initial
    begin
        int            rand_items;
        int            seq_len;
        int            style;
        int            run;
        int            k;
        logic [DW-1:0] v;
        logic          f;

        req_ch.valid = 1'b0;
        req_ch.value = '0;
        req_ch.first = 1'b0;
        res_ch.ready = 1'b0;
        rst_n        = 1'b0;
        burst_left   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes are ignored, equal values replace, first clears.
        send_elem(32'd0, 1'b1);
        send_elem(VAL_MIN, 1'b0);
        send_elem(VAL_MAX, 1'b0);
        send_elem(VAL_MIN + 1, 1'b0);
        send_elem(VAL_MAX - 1, 1'b0);
        send_elem(-32'sd1, 1'b0);
        send_elem(-32'sd1, 1'b0);
        send_elem(32'd5, 1'b0);
        send_elem(32'd5, 1'b0);
        send_elem(32'd3, 1'b0);
        send_elem(32'd4, 1'b0);
        send_elem(VAL_MAX, 1'b1);
        send_elem(VAL_MIN, 1'b0);
        send_elem(32'd100, 1'b0);
        send_elem(32'd50, 1'b0);
        send_elem(32'd25, 1'b0);
        send_elem(32'h5555_5555, 1'b1);
        send_elem(32'hAAAA_AAAA, 1'b0);
        send_elem(32'hFFFF_FFFE, 1'b0);
        send_elem(VAL_MAX - 1, 1'b0);
        send_elem(VAL_MIN, 1'b1);
        send_elem(VAL_MIN + 1, 1'b0);

        // Random sequences of several shapes.
        rand_items = 0;
        while (rand_items < N_RANDOM)
        begin
            seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 30);
            style   = $urandom_range(0, 5);
            run     = $signed($urandom) >>> 4;
            for (k = 0; k < seq_len; k++)
            begin
                case (style)
                    0: v = $urandom;
                    1: v = $urandom_range(0, 31) - 16;
                    2:
                    begin
                        run += $urandom_range(0, 50);
                        v = ($urandom_range(0, 5) == 0) ? $urandom : run;
                    end
                    3:
                    begin
                        run -= $urandom_range(0, 50);
                        v = run;
                    end
                    4:
                        v = $urandom_range(0, 1) ? VAL_MIN + $urandom_range(0, 3)
                                                 : VAL_MAX - $urandom_range(0, 3);
                    default:
                    begin
                        run += $urandom_range(0, 200) - 60;
                        v = run;
                    end
                endcase
                if ($urandom_range(0, 23) == 0)
                    v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
                f = (k == 0) ? 1'b1 : ($urandom_range(0, 60) == 0);
                send_elem(v, f);
                rand_items++;
            end
        end
        req_ch.valid <= 1'b0;

        // Drain, then let the chain's latency pass before the verdict.
        while (pending_cnt != 0)
            @(posedge clk);
        repeat (MAX_LEN + 16) @(posedge clk);
        if (fail_cnt == 0 && pending_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/lisl_pkg.sv
hw/rtl/lisl_ifs.sv
hw/rtl/lisl_cell.sv
hw/rtl/lisl_result.sv
hw/rtl/longest_increasing_subsequence_length_unit.sv
test/lisl_length_check.sv
test/tb_longest_increasing_subsequence_length_unit.sv
